// ----- hdl/swsed_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsed_pkg
// Shared types and constants for the single-wire sensor edge decoder.
// ----------------------------------------------------------------------------
package swsed_pkg;

    localparam int unsigned TIME_W      = 16;
    localparam int unsigned PCOUNT_W    = 6;
    localparam int unsigned DATA_BITS   = 40;
    localparam int unsigned BYTE_W      = 8;

    localparam logic [PCOUNT_W-1:0] PULSES_NEEDED = 6'd41;
    localparam logic [TIME_W-1:0]   THRESHOLD_RESET = 16'd50;
    localparam logic [TIME_W-1:0]   SIGN_BIT = 16'h8000;
    localparam logic [TIME_W-1:0]   MAG_MASK = 16'h7FFF;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_CHECKSUM = 2'd2
    } status_t;

    // packed as it travels on the result data bus, humidity in the low half
    typedef struct packed {
        logic [TIME_W-1:0] temperature_tenths;
        logic [TIME_W-1:0] humidity_tenths;
    } reading_t;

endpackage

// ----- hdl/single_wire_sensor_edge_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_sensor_edge_decoder
// Decodes a captured single-wire sensor frame from its bus edges.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one captured edge per request: s_tdata holds the
//   16-bit timer value, s_tuser the line level after the edge, and s_tlast
//   marks the final edge of a frame. On that final edge one result request
//   leaves on the m_ channel: m_tuser is the status (ok, short frame,
//   checksum mismatch) and m_tdata holds humidity and signed temperature,
//   both in tenths, and zero on error. Edges that are not last give nothing.
//   The cfg_ channel writes the bit threshold; write it only while idle.
//   An accepted edge is held in the input register; the frame state is
//   updated and the result decoded on the way into the result register.
//   Throughput: one edge per cycle, except while a last edge is stalled.
//   Reset clears the frame state, empties both registers and sets the
//   threshold to 50 ticks. While m_tready is low a pending result is held;
//   edges that are not last keep flowing, and a last edge waits in the
//   input register until the result register frees.
// ----------------------------------------------------------------------------
module single_wire_sensor_edge_decoder #(
    parameter int unsigned EDGE_CAP = 90
) (
    input  logic        aclk,
    input  logic        aresetn,
    // edge channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] edge_time
    input  logic        s_tuser,   // [0] line_level
    input  logic        s_tlast,   // frame_last
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths
    output logic [1:0]  m_tuser,   // [1:0] status
    // threshold write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int unsigned EDGE_W = $clog2(EDGE_CAP + 1);
    localparam logic [EDGE_W-1:0] EDGE_LIMIT = EDGE_W'(EDGE_CAP);
    localparam int unsigned TW = swsed_pkg::TIME_W;
    localparam int unsigned PW = swsed_pkg::PCOUNT_W;
    localparam int unsigned BW = swsed_pkg::BYTE_W;

    logic [TW-1:0]     threshold_reg;

    logic              in_valid_reg;
    logic [TW-1:0]     in_time_reg;
    logic              in_level_reg;
    logic              in_last_reg;

    logic              rise_pending_reg, rise_pending_next;
    logic [TW-1:0]     rise_time_reg, rise_time_next;
    logic [PW-1:0]     pulse_count_reg, pulse_count_next;
    logic [EDGE_W-1:0] edges_seen_reg, edges_seen_next;
    logic [swsed_pkg::DATA_BITS-1:0] frame_bits_reg, frame_bits_next;

    logic              out_valid_reg;
    swsed_pkg::status_t  status_reg, status_next;
    swsed_pkg::reading_t reading_reg, reading_next;

    logic          advance, take, take_last;
    logic          counted, fall, pulse_ok;
    logic [TW-1:0] width;
    logic          data_bit;
    logic [BW-1:0] b0, b1, b2, b3, b4, sum;
    logic [TW-1:0] raw_temp;

    assign cfg_ready = 1'b1;

    // a last edge needs room in the result register
    assign advance   = !in_last_reg || !out_valid_reg || m_tready;
    assign take      = in_valid_reg && advance;
    assign take_last = take && in_last_reg;
    assign s_tready  = !in_valid_reg || advance;

    always_comb begin
        counted  = edges_seen_reg < EDGE_LIMIT;
        fall     = counted && !in_level_reg && rise_pending_reg;
        pulse_ok = fall && (pulse_count_reg < swsed_pkg::PULSES_NEEDED);
        width    = in_time_reg - rise_time_reg;
        data_bit = width > threshold_reg;

        rise_pending_next = rise_pending_reg;
        rise_time_next    = rise_time_reg;
        pulse_count_next  = pulse_count_reg;
        edges_seen_next   = edges_seen_reg;
        frame_bits_next   = frame_bits_reg;

        if (counted) begin
            edges_seen_next = edges_seen_reg + 1'b1;
            if (in_level_reg) begin
                if (!rise_pending_reg) begin
                    rise_pending_next = 1'b1;
                    rise_time_next    = in_time_reg;
                end
            end else if (rise_pending_reg) begin
                rise_pending_next = 1'b0;
            end
        end
        if (pulse_ok) begin
            pulse_count_next = pulse_count_reg + 1'b1;
            // skip the acknowledge pulse
            if (pulse_count_reg != '0) begin
                frame_bits_next = {frame_bits_reg[swsed_pkg::DATA_BITS-2:0], data_bit};
            end
        end

        b0 = frame_bits_next[39:32];
        b1 = frame_bits_next[31:24];
        b2 = frame_bits_next[23:16];
        b3 = frame_bits_next[15:8];
        b4 = frame_bits_next[7:0];
        sum = b0 + b1 + b2 + b3;
        raw_temp = {b2, b3};

        reading_next = '0;
        if (pulse_count_next < swsed_pkg::PULSES_NEEDED) begin
            status_next = swsed_pkg::STATUS_SHORT;
        end else if (sum != b4) begin
            status_next = swsed_pkg::STATUS_CHECKSUM;
        end else begin
            status_next = swsed_pkg::STATUS_OK;
            reading_next.humidity_tenths = {b0, b1};
            if ((raw_temp & swsed_pkg::SIGN_BIT) != '0) begin
                reading_next.temperature_tenths = '0 - (raw_temp & swsed_pkg::MAG_MASK);
            end else begin
                reading_next.temperature_tenths = raw_temp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= swsed_pkg::THRESHOLD_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            rise_pending_reg <= 1'b0;
            rise_time_reg    <= '0;
            pulse_count_reg  <= '0;
            edges_seen_reg   <= '0;
            frame_bits_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                threshold_reg <= cfg_data;
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (take) begin
                in_valid_reg <= 1'b0;
            end

            if (take_last) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (take_last) begin
                // frame done: drop all frame state
                rise_pending_reg <= 1'b0;
                rise_time_reg    <= '0;
                pulse_count_reg  <= '0;
                edges_seen_reg   <= '0;
                frame_bits_reg   <= '0;
            end else if (take) begin
                rise_pending_reg <= rise_pending_next;
                rise_time_reg    <= rise_time_next;
                pulse_count_reg  <= pulse_count_next;
                edges_seen_reg   <= edges_seen_next;
                frame_bits_reg   <= frame_bits_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_time_reg  <= s_tdata;
            in_level_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (take_last) begin
            status_reg  <= status_next;
            reading_reg <= reading_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = reading_reg;

    a_pulse_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pulse_count_reg <= swsed_pkg::PULSES_NEEDED)
        else $error("pulse count past saturation");

    a_edge_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        edges_seen_reg <= EDGE_LIMIT)
        else $error("edge count past limit");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        take_last |=> m_tvalid && pulse_count_reg == '0 && edges_seen_reg == '0)
        else $error("last edge did not produce a result and clear the frame");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != swsed_pkg::STATUS_OK |-> m_tdata == '0)
        else $error("error result carries nonzero data");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !take_last)
        else $error("result overwritten while stalled");

endmodule
